// ----- hw/rtl/eot_pkg.sv -----
// Shared types, constants and functions of the encoder odometry tracker.
`default_nettype none
package eot_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_ENTRIES         = 24;
   localparam int QUEUE_DEPTH          = 4;

   localparam logic [31:0] INV_WHEEL_BASE_RESET     = 32'd546047;
   localparam logic [23:0] INV_TICKS_PER_UNIT_RESET = 24'd573776;

   localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414357;
   localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
   localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   typedef enum logic {
      REG_INV_WHEEL_BASE     = 1'b0,
      REG_INV_TICKS_PER_UNIT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_LEFT   = 2'd0,
      MODE_RIGHT  = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type op;
      logic     up;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIST,
      ST_HMUL,
      ST_HSUM,
      ST_CSTART,
      ST_ROT,
      ST_SMUL,
      ST_SADD,
      ST_UMUL,
      ST_PUSH
   } back_state_type;

   typedef enum logic [2:0] {
      C_IDLE,
      C_MOD,
      C_RANGE,
      C_ROT,
      C_DONE
   } cordic_state_type;

   function automatic logic [23:0] atan_q24(input logic [4:0] idx);
      logic [23:0] v;
      unique case (idx)
         5'd0:  v = 24'd13176795;
         5'd1:  v = 24'd7778716;
         5'd2:  v = 24'd4110060;
         5'd3:  v = 24'd2086331;
         5'd4:  v = 24'd1047214;
         5'd5:  v = 24'd524117;
         5'd6:  v = 24'd262123;
         5'd7:  v = 24'd131069;
         5'd8:  v = 24'd65536;
         5'd9:  v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic neg, input logic [57:0] mag);
      logic signed [31:0] r;
      if (neg) begin
         if (mag > 58'h8000_0000) r = 32'sh8000_0000;
         else                     r = -$signed(mag[31:0]);
      end else begin
         if (mag > 58'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
         else                     r = $signed(mag[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] bump16(input logic signed [15:0] c, input logic up);
      logic signed [15:0] r;
      if (up) r = (c != 16'sh7FFF) ? c + 16'sd1 : c;
      else    r = (c != 16'sh8000) ? c - 16'sd1 : c;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/eot_front.sv -----
// Front end: accepts input words, classifies them and queues the commands.
`default_nettype none
module eot_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic [1:0]       req_mode,
   input  wire logic             req_dir_level,
   output logic                  req_full,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output eot_pkg::cmd_type      cmd
);
   import eot_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   cmd_type         new_cmd;
   logic            do_push;
   logic            do_pop;

   always_comb begin
      new_cmd.op = mode_type'(req_mode);
      new_cmd.up = (new_cmd.op == MODE_RIGHT) ? ~req_dir_level : req_dir_level;
   end

   assign req_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push & ~req_full;
   assign do_pop    = cmd_valid & cmd_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/eot_cordic.sv -----
// Iterative CORDIC that reduces a Q7.24 angle and returns its cosine and sine in Q30.
`default_nettype none
module eot_cordic #(
   parameter int CORDIC_STEPS = eot_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] angle,
   output logic                    done,
   output logic signed [33:0]      cos_q30,
   output logic signed [33:0]      sin_q30
);
   import eot_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   cordic_state_type   state_ff, state_in;
   logic [2:0]         k_ff;
   logic [31:0]        mag_ff;
   logic               neg_ff;
   logic [4:0]         i_ff;
   logic signed [31:0] z_ff;
   logic signed [33:0] x_ff, y_ff;
   logic               flip_ff;
   logic [31:0]        sub_val;
   logic signed [31:0] zr, za;
   logic               flip_a;
   logic signed [33:0] xs, ys;
   logic signed [31:0] at;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C_IDLE:  if (start) state_in = C_MOD;
         C_MOD:   if (k_ff == 3'd0) state_in = C_RANGE;
         C_RANGE: state_in = C_ROT;
         C_ROT:   if (i_ff == 5'(NSTEPS - 1)) state_in = C_DONE;
         C_DONE:  state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == C_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= C_IDLE;
      else       state_ff <= state_in;
   end

   assign sub_val = $unsigned(TWO_PI_Q24) << k_ff;

   always_comb begin
      zr = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
      if (zr > PI_Q24) zr = zr - TWO_PI_Q24;
      else if (zr < -PI_Q24) zr = zr + TWO_PI_Q24;
      flip_a = 1'b0;
      za     = zr;
      if (zr > HALF_PI_Q24) begin
         za     = zr - PI_Q24;
         flip_a = 1'b1;
      end else if (zr < -HALF_PI_Q24) begin
         za     = zr + PI_Q24;
         flip_a = 1'b1;
      end
   end

   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = $signed({8'd0, atan_q24(i_ff)});

   always_ff @(posedge clock) begin
      unique case (state_ff)
         C_IDLE: begin
            neg_ff <= angle[31];
            mag_ff <= angle[31] ? 32'(-angle) : angle;
            k_ff   <= 3'd4;
         end
         C_MOD: begin
            if (mag_ff >= sub_val) mag_ff <= mag_ff - sub_val;
            k_ff <= k_ff - 3'd1;
         end
         C_RANGE: begin
            z_ff    <= za;
            flip_ff <= flip_a;
            x_ff    <= GAIN_Q30;
            y_ff    <= '0;
            i_ff    <= '0;
         end
         C_ROT: begin
            if (!z_ff[31]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + 5'd1;
         end
         C_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign cos_q30 = flip_ff ? -x_ff : x_ff;
   assign sin_q30 = flip_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/eot_back.sv -----
// Back end: odometry state, update sequencer, arithmetic and the result register.
`default_nettype none
module eot_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wdata,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire eot_pkg::cmd_type   cmd,
   output logic                    cordic_start,
   output logic signed [31:0]      cordic_angle,
   input  wire logic               cordic_done,
   input  wire logic signed [33:0] cordic_cos,
   input  wire logic signed [33:0] cordic_sin,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_heading,
   output logic signed [31:0]      rsp_distance,
   output logic signed [31:0]      rsp_left_total,
   output logic signed [31:0]      rsp_right_total,
   output logic signed [15:0]      rsp_left_speed,
   output logic signed [15:0]      rsp_right_speed
);
   import eot_pkg::*;

   back_state_type     state_ff, state_in;
   logic [31:0]        inv_wb_ff;
   logic [23:0]        inv_tpu_ff;
   logic signed [15:0] lpc_ff, rpc_ff;
   logic signed [15:0] lspd_ff, rspd_ff;
   logic signed [31:0] lsum_ff, rsum_ff;
   logic signed [31:0] prev_ff;
   logic signed [47:0] xacc_ff, yacc_ff;
   logic signed [31:0] heading_ff;
   logic signed [32:0] speed_ff;
   logic               hneg_ff;
   logic [32:0]        hmag_ff;
   logic [48:0]        hp_hi_ff, hp_lo_ff;
   logic signed [33:0] cos_ff, sin_ff;
   logic signed [50:0] px_hi_ff, px_lo_ff, py_hi_ff, py_lo_ff;
   logic               uxneg_ff, uyneg_ff;
   logic [47:0]        ux_hi_ff, ux_lo_ff, uy_hi_ff, uy_lo_ff;
   logic               out_valid_ff;
   logic               out_load;
   logic               slot_free;

   logic signed [33:0] sum34;
   logic signed [31:0] mean_dist;
   logic signed [32:0] diff;
   logic [57:0]        hq;
   logic signed [16:0] sp_hi, sp_lo;
   logic signed [67:0] prod_x, prod_y;
   logic signed [55:0] acc_x, acc_y;
   logic [47:0]        mag_x, mag_y;
   logic [48:0]        ru_x, ru_y;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_wb_ff  <= INV_WHEEL_BASE_RESET;
         inv_tpu_ff <= INV_TICKS_PER_UNIT_RESET;
      end else if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_INV_WHEEL_BASE:     inv_wb_ff  <= csr_wdata;
            REG_INV_TICKS_PER_UNIT: inv_tpu_ff <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   assign slot_free = ~out_valid_ff | rsp_pop;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) state_in = (cmd.op == MODE_UPDATE) ? ST_SUM : ST_UMUL;
         end
         ST_SUM:    state_in = ST_DIST;
         ST_DIST:   state_in = ST_HMUL;
         ST_HMUL:   state_in = ST_HSUM;
         ST_HSUM:   state_in = ST_CSTART;
         ST_CSTART: state_in = ST_ROT;
         ST_ROT:    if (cordic_done) state_in = ST_SMUL;
         ST_SMUL:   state_in = ST_SADD;
         ST_SADD:   state_in = ST_UMUL;
         ST_UMUL:   state_in = ST_PUSH;
         ST_PUSH:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_ready    = (state_ff == ST_IDLE);
      cordic_start = (state_ff == ST_CSTART);
      out_load     = (state_ff == ST_PUSH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign cordic_angle = heading_ff;

   always_comb begin
      sum34     = 34'(lsum_ff) + 34'(rsum_ff);
      mean_dist = 32'((sum34 + 34'($unsigned(sum34[33]))) >>> 1);
      diff      = 33'(rsum_ff) - 33'(lsum_ff);
      hq        = {1'b0, hp_hi_ff, 8'd0} + 58'(hp_lo_ff >> 8);
      sp_hi = speed_ff[32:16];
      sp_lo = $signed({1'b0, speed_ff[15:0]});
      prod_x = (68'(px_hi_ff) <<< 16) + 68'(px_lo_ff);
      prod_y = (68'(py_hi_ff) <<< 16) + 68'(py_lo_ff);
      acc_x  = 56'(xacc_ff) + 56'(prod_x >>> 14);
      acc_y  = 56'(yacc_ff) + 56'(prod_y >>> 14);
      mag_x  = xacc_ff[47] ? 48'(-xacc_ff) : xacc_ff;
      mag_y  = yacc_ff[47] ? 48'(-yacc_ff) : yacc_ff;
      ru_x   = ({1'b0, ux_hi_ff} + 49'(ux_lo_ff >> 24)) >> 16;
      ru_y   = ({1'b0, uy_hi_ff} + 49'(uy_lo_ff >> 24)) >> 16;
   end

   // State and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         lpc_ff     <= '0;
         rpc_ff     <= '0;
         lsum_ff    <= '0;
         rsum_ff    <= '0;
         prev_ff    <= '0;
         xacc_ff    <= '0;
         yacc_ff    <= '0;
         heading_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  lspd_ff <= lpc_ff;
                  rspd_ff <= rpc_ff;
                  if (cmd.op == MODE_LEFT) begin
                     lpc_ff  <= bump16(lpc_ff, cmd.up);
                     lspd_ff <= bump16(lpc_ff, cmd.up);
                  end else if (cmd.op == MODE_RIGHT) begin
                     rpc_ff  <= bump16(rpc_ff, cmd.up);
                     rspd_ff <= bump16(rpc_ff, cmd.up);
                  end
               end
            end
            ST_SUM: begin
               lsum_ff <= lsum_ff + 32'(lpc_ff);
               rsum_ff <= rsum_ff + 32'(rpc_ff);
               lspd_ff <= lpc_ff;
               rspd_ff <= rpc_ff;
               lpc_ff  <= '0;
               rpc_ff  <= '0;
            end
            ST_DIST: begin
               speed_ff <= 33'(mean_dist) - 33'(prev_ff);
               prev_ff  <= mean_dist;
               hneg_ff  <= diff[32];
               hmag_ff  <= diff[32] ? 33'(-diff) : 33'(diff);
            end
            ST_HMUL: begin
               hp_hi_ff <= hmag_ff * inv_wb_ff[31:16];
               hp_lo_ff <= hmag_ff * inv_wb_ff[15:0];
            end
            ST_HSUM: begin
               heading_ff <= sat32(hneg_ff, hq);
            end
            ST_ROT: begin
               if (cordic_done) begin
                  cos_ff <= cordic_cos;
                  sin_ff <= cordic_sin;
               end
            end
            ST_SMUL: begin
               px_hi_ff <= sp_hi * cos_ff;
               px_lo_ff <= sp_lo * cos_ff;
               py_hi_ff <= sp_hi * sin_ff;
               py_lo_ff <= sp_lo * sin_ff;
            end
            ST_SADD: begin
               if (acc_x > 56'(ACC_MAX))      xacc_ff <= ACC_MAX;
               else if (acc_x < 56'(ACC_MIN)) xacc_ff <= ACC_MIN;
               else                           xacc_ff <= acc_x[47:0];
               if (acc_y > 56'(ACC_MAX))      yacc_ff <= ACC_MAX;
               else if (acc_y < 56'(ACC_MIN)) yacc_ff <= ACC_MIN;
               else                           yacc_ff <= acc_y[47:0];
            end
            ST_UMUL: begin
               uxneg_ff <= xacc_ff[47];
               uyneg_ff <= yacc_ff[47];
               ux_hi_ff <= mag_x[47:24] * inv_tpu_ff;
               ux_lo_ff <= mag_x[23:0] * inv_tpu_ff;
               uy_hi_ff <= mag_y[47:24] * inv_tpu_ff;
               uy_lo_ff <= mag_y[23:0] * inv_tpu_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pos_x       <= sat32(uxneg_ff, 58'(ru_x));
         rsp_pos_y       <= sat32(uyneg_ff, 58'(ru_y));
         rsp_heading     <= heading_ff;
         rsp_distance    <= prev_ff;
         rsp_left_total  <= lsum_ff;
         rsp_right_total <= rsum_ff;
         rsp_left_speed  <= lspd_ff;
         rsp_right_speed <= rspd_ff;
      end
   end

   assign rsp_empty = ~out_valid_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_pop))
      else $error("result loaded over a waiting word");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> !rsp_empty)
      else $error("loaded result not shown");
   a_period_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> (lpc_ff == 16'sd0 && rpc_ff == 16'sd0))
      else $error("period counts not cleared on update");
   a_cordic_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_start |=> state_ff == ST_ROT)
      else $error("sequencer left before rotation");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/encoder_odometry_tracker.sv -----
// Top level of the encoder odometry tracker: front queue, back end and CORDIC.
// An edge word or a mode-three word goes from acceptance through the UMUL and PUSH states to its result.
// An update word also passes through SUM, DIST, HMUL, HSUM, CSTART, ROT, SMUL and SADD, waiting in ROT for the CORDIC.
// Words are executed one at a time; a four-entry queue takes new words meanwhile.
// Synchronous active-high reset clears all odometry state and the queues.
// Reset loads the reciprocal registers with their default values.
`default_nettype none
module encoder_odometry_tracker #(
   parameter int CORDIC_STEPS = eot_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_en,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [1:0]   req_mode,
   input  wire logic         req_dir_level,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_heading,
   output logic signed [31:0] rsp_distance,
   output logic signed [31:0] rsp_left_total,
   output logic signed [31:0] rsp_right_total,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed
);
   import eot_pkg::*;

   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;
   logic               cordic_start;
   logic signed [31:0] cordic_angle;
   logic               cordic_done;
   logic signed [33:0] cordic_cos;
   logic signed [33:0] cordic_sin;

   eot_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_mode      (req_mode),
      .req_dir_level (req_dir_level),
      .req_full      (req_full),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd)
   );

   eot_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_q30 (cordic_cos),
      .sin_q30 (cordic_sin)
   );

   eot_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .cordic_start    (cordic_start),
      .cordic_angle    (cordic_angle),
      .cordic_done     (cordic_done),
      .cordic_cos      (cordic_cos),
      .cordic_sin      (cordic_sin),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_heading     (rsp_heading),
      .rsp_distance    (rsp_distance),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the encoder odometry tracker with its own odometry predictor.
`timescale 1ns / 100ps
module tb;
   import eot_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEFAULT;
   localparam int SETTLE = STEPS + 40;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      mode_type op;
      logic     dir;
   } edge_word_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic signed [31:0] distance;
      logic signed [31:0] left_total;
      logic signed [31:0] right_total;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
   } odo_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   reg_index_type csr_index = REG_INV_WHEEL_BASE;
   logic [31:0] csr_wdata = '0;
   logic req_push = 1'b0;
   logic req_full;
   logic [1:0] req_mode = MODE_NONE;
   logic req_dir_level = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_heading, rsp_distance;
   logic signed [31:0] rsp_left_total, rsp_right_total;
   logic signed [15:0] rsp_left_speed, rsp_right_speed;

   encoder_odometry_tracker #(.CORDIC_STEPS(STEPS)) DUT (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full),
      .req_mode(req_mode), .req_dir_level(req_dir_level),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_heading(rsp_heading),
      .rsp_distance(rsp_distance), .rsp_left_total(rsp_left_total),
      .rsp_right_total(rsp_right_total), .rsp_left_speed(rsp_left_speed),
      .rsp_right_speed(rsp_right_speed)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   edge_word_type  words_to_send[$];
   odo_report_type reports_due[$];
   int errors = 0;
   int idle_cycles = 0;
   int reports_seen = 0;

   // Predictor state and register copies.
   logic [31:0] wheel_base_recip;
   logic [23:0] unit_recip;
   logic signed [15:0] left_count, right_count;
   logic [31:0] left_acc, right_acc;
   logic signed [31:0] last_dist, heading_now;
   longint x_pos, y_pos;

   localparam longint ARCTAN[24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};

   function automatic logic signed [31:0] clamp32(logic neg, longint unsigned mag);
      if (neg) return (mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(mag));
      return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
   endfunction

   function automatic logic signed [31:0] to_units(longint acc, logic [23:0] recip);
      longint unsigned m, hi, lo;
      m = (acc < 0) ? longint'(-acc) : acc;
      hi = m >> 24;
      lo = m & 64'hFF_FFFF;
      return clamp32(acc < 0, (hi * recip + ((lo * recip) >> 24)) >> 16);
   endfunction

   function automatic longint clamp48(longint s);
      if (s > longint'(ACC_MAX)) return longint'(ACC_MAX);
      if (s < longint'(ACC_MIN)) return longint'(ACC_MIN);
      return s;
   endfunction

   function automatic void rotate(logic signed [31:0] angle, output longint c,
                                  output longint s);
      longint z, x, y, xs, ys;
      logic flip;
      z = longint'(angle) % longint'(TWO_PI_Q24);
      x = longint'(GAIN_Q30);
      y = 0;
      flip = 1'b0;
      if (z > longint'(PI_Q24)) z -= longint'(TWO_PI_Q24);
      if (z < -longint'(PI_Q24)) z += longint'(TWO_PI_Q24);
      if (z > longint'(HALF_PI_Q24)) begin
         z -= longint'(PI_Q24);
         flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Q24)) begin
         z += longint'(PI_Q24);
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ARCTAN[i];
         end else begin
            x += ys; y -= xs; z += ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [15:0] count_step(logic signed [15:0] c, logic up);
      if (up) return (c != 16'sh7FFF) ? c + 16'sd1 : c;
      return (c != 16'sh8000) ? c - 16'sd1 : c;
   endfunction

   function automatic odo_report_type odometry_step(edge_word_type w);
      odo_report_type r;
      longint ls, rs, mean_dist, speed, cv, sv, diff;
      longint unsigned m, q;
      logic [15:0] lspd, rspd;
      lspd = left_count;
      rspd = right_count;
      case (w.op)
         MODE_LEFT: begin
            left_count = count_step(left_count, w.dir);
            lspd = left_count;
         end
         MODE_RIGHT: begin
            right_count = count_step(right_count, !w.dir);
            rspd = right_count;
         end
         MODE_UPDATE: begin
            left_acc += 32'(left_count);
            right_acc += 32'(right_count);
            left_count = '0;
            right_count = '0;
            ls = longint'($signed(left_acc));
            rs = longint'($signed(right_acc));
            mean_dist = (ls + rs) / 2;
            speed = mean_dist - longint'(last_dist);
            last_dist = 32'(mean_dist);
            diff = rs - ls;
            m = (diff < 0) ? longint'(-diff) : diff;
            q = m * (wheel_base_recip >> 16) * 256
                + ((m * (wheel_base_recip & 32'hFFFF)) >> 8);
            heading_now = clamp32(diff < 0, q);
            rotate(heading_now, cv, sv);
            x_pos = clamp48(x_pos + ((speed * cv) >>> 14));
            y_pos = clamp48(y_pos + ((speed * sv) >>> 14));
         end
         default: ;
      endcase
      r.pos_x = to_units(x_pos, unit_recip);
      r.pos_y = to_units(y_pos, unit_recip);
      r.heading = heading_now;
      r.distance = last_dist;
      r.left_total = left_acc;
      r.right_total = right_acc;
      r.left_speed = lspd;
      r.right_speed = rspd;
      return r;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      logic next_push;
      edge_word_type w;
      next_push = req_push;
      if (!reset) begin
         if (req_push && !req_full) begin
            w.op = mode_type'(req_mode);
            w.dir = req_dir_level;
            reports_due.push_back(odometry_step(w));
            next_push = 1'b0;
         end
         if (!next_push) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (words_to_send.size() > 0) begin
               w = words_to_send.pop_front();
               req_mode <= w.op;
               req_dir_level <= w.dir;
               next_push = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_push <= next_push;
   end

   // Receiver: stall pattern changes every 64 words; one long hold-off.
   int hold_left = 0;
   logic held_once = 1'b0;
   always @(posedge clock) begin
      odo_report_type e;
      logic next_pop;
      int pattern;
      if (!reset && rsp_pop && !rsp_empty) begin
         reports_seen++;
         if (reports_due.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected", $time);
         end else begin
            e = reports_due.pop_front();
            if ({rsp_pos_x, rsp_pos_y, rsp_heading, rsp_distance, rsp_left_total,
                 rsp_right_total, rsp_left_speed, rsp_right_speed} !==
                {e.pos_x, e.pos_y, e.heading, e.distance, e.left_total,
                 e.right_total, e.left_speed, e.right_speed}) begin
               errors++;
               $display("%0t: expected x %0d y %0d hd %0d dist %0d lt %0d rt %0d ls %0d rs %0d",
                        $time, e.pos_x, e.pos_y, e.heading, e.distance, e.left_total,
                        e.right_total, e.left_speed, e.right_speed);
               $display("%0t: actual   x %0d y %0d hd %0d dist %0d lt %0d rt %0d ls %0d rs %0d",
                        $time, rsp_pos_x, rsp_pos_y, rsp_heading, rsp_distance,
                        rsp_left_total, rsp_right_total, rsp_left_speed, rsp_right_speed);
            end
         end
         if (reports_seen == 300 && !held_once) begin
            held_once = 1'b1;
            hold_left = 200;
         end
      end
      pattern = (reports_seen / 64) % 3;
      if (hold_left > 0) begin
         hold_left--;
         next_pop = 1'b0;
      end else if (pattern == 0) begin
         next_pop = 1'b1;
      end else if (pattern == 1) begin
         next_pop = $urandom_range(0, 1);
      end else begin
         next_pop = ($urandom_range(0, 3) == 0);
      end
      rsp_pop <= reset ? 1'b0 : next_pop;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic add_word(mode_type op, logic dir);
      edge_word_type w;
      w.op = op;
      w.dir = dir;
      words_to_send.push_back(w);
   endtask

   task automatic add_random(int n);
      int bias;
      int r;
      bias = $urandom_range(10, 90);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (i % 50 == 0) bias = $urandom_range(10, 90);
         if (r < 44)      add_word(MODE_LEFT, $urandom_range(0, 99) < bias);
         else if (r < 88) add_word(MODE_RIGHT, $urandom_range(0, 99) >= bias);
         else if (r < 97) add_word(MODE_UPDATE, $urandom_range(0, 1));
         else             add_word(MODE_NONE, $urandom_range(0, 1));
      end
   endtask

   task automatic drain();
      while (words_to_send.size() != 0 || req_push || reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_INV_WHEEL_BASE) wheel_base_recip = value;
      else                           unit_recip = value[23:0];
   endtask

   initial begin
      wheel_base_recip = INV_WHEEL_BASE_RESET;
      unit_recip = INV_TICKS_PER_UNIT_RESET;
      left_count = '0;
      right_count = '0;
      left_acc = '0;
      right_acc = '0;
      last_dist = '0;
      heading_now = '0;
      x_pos = 0;
      y_pos = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_word(MODE_UPDATE, 1'b0);
      add_word(MODE_LEFT, 1'b1);
      add_word(MODE_LEFT, 1'b0);
      add_word(MODE_LEFT, 1'b1);
      add_word(MODE_RIGHT, 1'b0);
      add_word(MODE_RIGHT, 1'b1);
      add_word(MODE_RIGHT, 1'b0);
      add_word(MODE_RIGHT, 1'b0);
      add_word(MODE_NONE, 1'b0);
      add_word(MODE_NONE, 1'b1);
      add_word(MODE_UPDATE, 1'b1);
      for (int i = 0; i < 8; i++) add_word(MODE_RIGHT, 1'b0);
      add_word(MODE_UPDATE, 1'b0);
      for (int i = 0; i < 5; i++) add_word(MODE_LEFT, 1'b0);
      add_word(MODE_UPDATE, 1'b0);
      drain();

      add_random(300);
      drain();

      write_reg(REG_INV_WHEEL_BASE, 32'hFFFF_FFFF);
      write_reg(REG_INV_TICKS_PER_UNIT, 32'h00FF_FFFF);
      for (int i = 0; i < 150; i++) add_word(MODE_RIGHT, 1'b0);
      add_word(MODE_UPDATE, 1'b0);
      for (int i = 0; i < 300; i++) add_word(MODE_RIGHT, 1'b1);
      add_word(MODE_UPDATE, 1'b0);
      add_random(100);
      drain();

      write_reg(REG_INV_WHEEL_BASE, 32'd1);
      write_reg(REG_INV_TICKS_PER_UNIT, 32'd1);
      add_random(100);
      drain();

      write_reg(REG_INV_WHEEL_BASE, 32'd0);
      write_reg(REG_INV_TICKS_PER_UNIT, 32'd0);
      add_random(80);
      drain();

      write_reg(REG_INV_WHEEL_BASE, $urandom_range(1000, 32'h00FF_FFFF) << $urandom_range(0, 8));
      write_reg(REG_INV_TICKS_PER_UNIT, $urandom_range(1, 32'h00FF_FFFF));
      add_random(100);
      drain();

      write_reg(REG_INV_WHEEL_BASE, INV_WHEEL_BASE_RESET);
      write_reg(REG_INV_TICKS_PER_UNIT, INV_TICKS_PER_UNIT_RESET);
      add_random(100);
      drain();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/eot_pkg.sv
hw/rtl/eot_front.sv
hw/rtl/eot_cordic.sv
hw/rtl/eot_back.sv
hw/rtl/encoder_odometry_tracker.sv
tb/tb.sv
